// ----- rtl/vfc_pkg.sv -----
`default_nettype none

package vfc_pkg;

    localparam int COORD_BITS = 16;
    localparam int VERT_BITS  = COORD_BITS + 1;
    localparam int INDEX_BITS = 17;
    localparam int NUM_FACES  = 6;
    localparam int CORNERS    = 4;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    typedef logic [2:0] t_face;
    typedef logic [1:0] t_corner;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // one classified voxel; faces holds the exposed faces (zero if empty voxel)
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         start;
        logic [NUM_FACES-1:0]         faces;
    } t_item;

    // corner offsets, bit 0 = dx, bit 1 = dy, bit 2 = dz
    function automatic logic [2:0] corner_offset(input t_face f, input t_corner c);
        logic [2:0] off;
        case ({f, c})
            // +x
            5'b000_00: off = 3'b001;
            5'b000_01: off = 3'b011;
            5'b000_10: off = 3'b111;
            5'b000_11: off = 3'b101;
            // -x
            5'b001_00: off = 3'b100;
            5'b001_01: off = 3'b110;
            5'b001_10: off = 3'b010;
            5'b001_11: off = 3'b000;
            // +y
            5'b010_00: off = 3'b010;
            5'b010_01: off = 3'b110;
            5'b010_10: off = 3'b111;
            5'b010_11: off = 3'b011;
            // -y
            5'b011_00: off = 3'b001;
            5'b011_01: off = 3'b101;
            5'b011_10: off = 3'b100;
            5'b011_11: off = 3'b000;
            // +z
            5'b100_00: off = 3'b101;
            5'b100_01: off = 3'b111;
            5'b100_10: off = 3'b110;
            5'b100_11: off = 3'b100;
            // -z
            5'b101_00: off = 3'b000;
            5'b101_01: off = 3'b010;
            5'b101_10: off = 3'b011;
            5'b101_11: off = 3'b001;
            default:   off = 3'b000;
        endcase
        return off;
    endfunction

    function automatic t_axis face_axis(input t_face f);
        t_axis a;
        case (f)
            3'd0, 3'd1: a = AXIS_X;
            3'd2, 3'd3: a = AXIS_Y;
            default:    a = AXIS_Z;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/voxel_face_cull_quad_emitter.sv -----
// An input voxel passes the front register, the queue and the sequencer's working registers to the output register.
// Throughput: one vertex per cycle within a voxel while i_ready holds, set by the single
// vertex port; a voxel holds the sequencer for a load step plus four vertices per exposed face.
// A 4-entry queue lets the input side run ahead of the vertex sequencer.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears the vertex counter.
`default_nettype none

module voxel_face_cull_quad_emitter
    import vfc_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output      logic                         o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_voxel_x,
    input  wire logic signed [COORD_BITS-1:0] i_voxel_y,
    input  wire logic signed [COORD_BITS-1:0] i_voxel_z,
    input  wire logic                         i_voxel_solid,
    input  wire logic [NUM_FACES-1:0]         i_neighbor_solid,
    input  wire logic                         i_start_mesh,
    output      logic                         o_valid,
    input  wire logic                         i_ready,
    output      logic signed [VERT_BITS-1:0]  o_vert_x,
    output      logic signed [VERT_BITS-1:0]  o_vert_y,
    output      logic signed [VERT_BITS-1:0]  o_vert_z,
    output      logic [1:0]                   o_normal_axis,
    output      logic                         o_normal_negative,
    output      logic [INDEX_BITS-1:0]        o_vertex_index,
    output      logic                         o_last_vertex
);

    logic  f_push;
    logic  q_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    // intake and face classification
    vfc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_voxel_x        (i_voxel_x),
        .i_voxel_y        (i_voxel_y),
        .i_voxel_z        (i_voxel_z),
        .i_voxel_solid    (i_voxel_solid),
        .i_neighbor_solid (i_neighbor_solid),
        .i_start_mesh     (i_start_mesh),
        .o_push           (f_push),
        .i_q_ready        (q_ready),
        .o_item           (f_item)
    );

    // decoupling queue
    vfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .o_ready (q_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    // vertex sequencer
    vfc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_vert_x          (o_vert_x),
        .o_vert_y          (o_vert_y),
        .o_vert_z          (o_vert_z),
        .o_normal_axis     (o_normal_axis),
        .o_normal_negative (o_normal_negative),
        .o_vertex_index    (o_vertex_index),
        .o_last_vertex     (o_last_vertex)
    );

endmodule

`default_nettype wire

// ----- rtl/vfc_front.sv -----
`default_nettype none

module vfc_front
    import vfc_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output      logic                         o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_voxel_x,
    input  wire logic signed [COORD_BITS-1:0] i_voxel_y,
    input  wire logic signed [COORD_BITS-1:0] i_voxel_z,
    input  wire logic                         i_voxel_solid,
    input  wire logic [NUM_FACES-1:0]         i_neighbor_solid,
    input  wire logic                         i_start_mesh,
    output      logic                         o_push,
    input  wire logic                         i_q_ready,
    output      t_item                        o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // classify: exposed faces of a solid voxel, none for an empty one
    always_comb begin
        n_item.x     = i_voxel_x;
        n_item.y     = i_voxel_y;
        n_item.z     = i_voxel_z;
        n_item.start = i_start_mesh;
        n_item.faces = i_voxel_solid ? ~i_neighbor_solid : '0;
    end

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vfc_queue.sv -----
`default_nettype none

module vfc_queue
    import vfc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output      logic  o_ready,
    input  wire t_item i_item,
    output      logic  o_valid,
    input  wire logic  i_pop,
    output      t_item o_item
);

    t_item                 r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_PTR_BITS:0]   r_count;
    logic                  wr_en;
    logic                  rd_en;

    assign o_ready = (r_count != (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign wr_en   = i_push && o_ready;
    assign rd_en   = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vfc_back.sv -----
`default_nettype none

module vfc_back
    import vfc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire t_item                       i_q_item,
    output      logic                        o_q_pop,
    output      logic                        o_valid,
    input  wire logic                        i_ready,
    output      logic signed [VERT_BITS-1:0] o_vert_x,
    output      logic signed [VERT_BITS-1:0] o_vert_y,
    output      logic signed [VERT_BITS-1:0] o_vert_z,
    output      logic [1:0]                  o_normal_axis,
    output      logic                        o_normal_negative,
    output      logic [INDEX_BITS-1:0]       o_vertex_index,
    output      logic                        o_last_vertex
);

    // working voxel
    logic                         r_busy;
    logic [NUM_FACES-1:0]         r_faces;
    t_corner                      r_corner;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic signed [COORD_BITS-1:0] r_z;
    logic [INDEX_BITS-1:0]        r_count;

    // output register
    logic                         r_out_valid;
    logic signed [VERT_BITS-1:0]  r_vx;
    logic signed [VERT_BITS-1:0]  r_vy;
    logic signed [VERT_BITS-1:0]  r_vz;
    t_axis                        r_axis;
    logic                         r_neg;
    logic [INDEX_BITS-1:0]        r_index;
    logic                         r_last;

    t_face                        cur_face;
    logic                         face_last;
    logic                         vert_last;
    logic                         emit;
    logic [2:0]                   off;
    logic [NUM_FACES-1:0]         n_faces;

    // lowest remaining exposed face
    always_comb begin
        cur_face = '0;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (r_faces[i]) begin
                cur_face = 3'(i);
            end
        end
    end

    assign face_last = ((r_faces & (r_faces - 1'b1)) == '0);
    assign vert_last = face_last && (r_corner == t_corner'(CORNERS - 1));
    assign emit      = r_busy && (!r_out_valid || i_ready);
    assign o_q_pop   = !r_busy;
    assign off       = corner_offset(cur_face, r_corner);
    assign n_faces   = (r_corner == t_corner'(CORNERS - 1))
                     ? (r_faces & ~(NUM_FACES'(1) << cur_face)) : r_faces;

    // sequencer control and vertex counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_corner    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_busy && i_q_valid) begin
                r_busy   <= (i_q_item.faces != '0);
                r_corner <= '0;
                if (i_q_item.start) begin
                    r_count <= '0;
                end
            end else if (emit) begin
                r_corner <= r_corner + 1'b1;
                if (vert_last) begin
                    r_busy <= 1'b0;
                end
                if (r_count != INDEX_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // voxel payload and remaining faces
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_q_valid) begin
            r_faces <= i_q_item.faces;
            r_x     <= i_q_item.x;
            r_y     <= i_q_item.y;
            r_z     <= i_q_item.z;
        end else if (emit) begin
            r_faces <= n_faces;
        end
    end

    // vertex payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_vx    <= VERT_BITS'(r_x) + VERT_BITS'(off[0]);
            r_vy    <= VERT_BITS'(r_y) + VERT_BITS'(off[1]);
            r_vz    <= VERT_BITS'(r_z) + VERT_BITS'(off[2]);
            r_axis  <= face_axis(cur_face);
            r_neg   <= cur_face[0];
            r_index <= r_count;
            r_last  <= vert_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_vert_x          = r_vx;
    assign o_vert_y          = r_vy;
    assign o_vert_z          = r_vz;
    assign o_normal_axis     = r_axis;
    assign o_normal_negative = r_neg;
    assign o_vertex_index    = r_index;
    assign o_last_vertex     = r_last;

endmodule

`default_nettype wire

// ----- rtl/vfc_checker.sv -----
`default_nettype none

module vfc_checker
    import vfc_pkg::*;
(
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic [1:0]                  o_normal_axis,
    input wire logic [INDEX_BITS-1:0]       o_vertex_index,
    input wire logic                        o_last_vertex
);

    // no vertex right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("vertex valid after reset");

    // stalled vertex holds its index
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_vertex_index))
        else $error("stalled vertex changed");

    // axis code 3 never appears
    a_axis_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_axis != 2'd3)
        else $error("illegal normal axis");

    // within a voxel the next vertex follows at once with the next index
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_vertex |=> o_valid &&
            (o_vertex_index == $past(o_vertex_index) + 1'b1 ||
             $past(o_vertex_index) == INDEX_MAX))
        else $error("vertex index did not advance");

endmodule

bind voxel_face_cull_quad_emitter vfc_checker u_vfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_normal_axis  (o_normal_axis),
    .o_vertex_index (o_vertex_index),
    .o_last_vertex  (o_last_vertex)
);

`default_nettype wire
